FILE: src/mtsd_pkg.sv
package mtsd_pkg;

    localparam int HISTORY_SAMPLES = 65536;
    localparam int TAP_COUNT       = 8;

    localparam int NUM_TAP_REGS = 8;
    localparam int TAP_IDX_W    = $clog2(NUM_TAP_REGS);
    localparam int SAMPLE_W     = 16;
    localparam int DELAY_W      = 16;
    localparam int SETTING_W    = 17;
    localparam int ENABLE_BIT   = 16;
    localparam int FILL_W       = 17;
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(65536);

    localparam int ADDR_W = $clog2(HISTORY_SAMPLES);
    localparam int CALC_W = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 1;

    localparam int TDATA_IN_W  = SAMPLE_W;
    localparam int TDATA_OUT_W = NUM_TAP_REGS * SAMPLE_W;

    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [SETTING_W-1:0] t_setting;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_OUT
    } t_state;

endpackage

FILE: src/multi_tap_sample_delay.sv
// Multi-tap sample delay line.
// Input stream (s_axis): one signed 16-bit sample per word. Output stream
// (m_axis): one word per input, holding the eight tap samples, tap 0 in the
// lowest bits. Tap k gives the sample received delay_k samples ago, delay 0
// being the current one; a disabled tap, or one reaching back before the
// first sample since reset, gives zero.
// Configuration: write enable, register index 0..7 and 17-bit data; bit 16
// enables the tap, bits 15..0 are its delay. Write only while idle.
// Timing: a sample is written into the single-port history memory in the cycle
// after acceptance, then the eight taps are read one per cycle through the
// same port and address unit, and a drain state lets the last read land. The
// result is then shown in the output state, and a new word is taken the cycle
// after the result is taken, so one word is processed at a time. The memory
// port is why the taps are read in turn.
// While a result waits, tready stays low and the result holds.
// Reset clears the write pointer, fill counter and tap settings; the history
// memory itself is not cleared, as the fill counter masks unwritten entries.
module multi_tap_sample_delay
    import mtsd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // sample_in
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // tap0_out .. tap7_out
    input  logic                   i_cfg_we,
    input  logic [TAP_IDX_W-1:0]   i_cfg_idx,
    input  logic [SETTING_W-1:0]   i_cfg_data
);

    t_state                r_state;
    t_state                n_state;
    t_sample               r_sample;
    logic [ADDR_W-1:0]     r_wptr;
    logic [FILL_W-1:0]     r_fill;
    t_setting              r_tap_set [NUM_TAP_REGS];
    logic [TAP_IDX_W-1:0]  r_tap;
    t_sample               r_rd_data;
    logic                  r_cap_vld;
    logic                  r_cap_use;
    logic [TAP_IDX_W-1:0]  r_cap_idx;
    t_sample               r_taps [NUM_TAP_REGS];
    t_sample               r_mem [HISTORY_SAMPLES];

    logic                  w_mem_we;
    logic                  w_rd_en;
    logic                  w_last_tap;
    logic [DELAY_W-1:0]    w_delay;
    logic                  w_en;
    logic [CALC_W-1:0]     w_diff;
    logic [CALC_W-1:0]     w_wrap;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic                  w_use;
    logic                  w_in_acc;
    logic                  w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;
    assign w_last_tap = (r_tap == TAP_IDX_W'(NUM_TAP_REGS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_axis_tvalid) n_state = S_WRITE;
            S_WRITE: n_state = S_READ;
            S_READ:  if (w_last_tap) n_state = S_DRAIN;
            S_DRAIN: n_state = S_OUT;
            S_OUT:   if (w_out_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_mem_we      = 1'b0;
        w_rd_en       = 1'b0;
        unique case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_WRITE: w_mem_we      = 1'b1;
            S_READ:  w_rd_en       = 1'b1;
            S_DRAIN: ;
            S_OUT:   m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign w_delay = r_tap_set[r_tap][DELAY_W-1:0];
    assign w_en    = r_tap_set[r_tap][ENABLE_BIT];
    assign w_diff  = CALC_W'(r_wptr) - CALC_W'(w_delay);
    assign w_wrap  = w_diff + CALC_W'(HISTORY_SAMPLES);
    assign w_rd_addr = w_diff[CALC_W-1] ? w_wrap[ADDR_W-1:0] : w_diff[ADDR_W-1:0];
    assign w_use = ((TAP_IDX_W + 1)'(r_tap) < (TAP_IDX_W + 1)'(TAP_COUNT))
                   && w_en
                   && (FILL_W'(w_delay) < r_fill)
                   && (CALC_W'(w_delay) < CALC_W'(HISTORY_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wptr    <= '0;
            r_fill    <= '0;
            r_tap     <= '0;
            r_cap_vld <= 1'b0;
            for (int k = 0; k < NUM_TAP_REGS; k++) begin
                r_tap_set[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_cap_vld <= w_rd_en;
            if (i_cfg_we) begin
                r_tap_set[i_cfg_idx] <= i_cfg_data;
            end
            if (w_mem_we && (r_fill < FILL_LIMIT)) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (w_rd_en) begin
                r_tap <= r_tap + TAP_IDX_W'(1);
            end
            if (r_state == S_DRAIN) begin
                if (r_wptr == ADDR_W'(HISTORY_SAMPLES - 1)) begin
                    r_wptr <= '0;
                end else begin
                    r_wptr <= r_wptr + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= s_axis_tdata;
        end
        r_cap_use <= w_use;
        r_cap_idx <= r_tap;
        if (r_cap_vld) begin
            r_taps[r_cap_idx] <= r_cap_use ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wptr] <= r_sample;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_TAP_REGS; k++) begin
            m_axis_tdata[k*SAMPLE_W +: SAMPLE_W] = r_taps[k];
        end
    end

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");

    a_accept_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_WRITE))
        else $error("accepted word not written next cycle");

    a_fill_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_LIMIT)
        else $error("fill counter beyond its limit");

    a_wptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CALC_W'(r_wptr) < CALC_W'(HISTORY_SAMPLES))
        else $error("write pointer out of range");

    a_tap_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_tap == '0) && !r_cap_vld)
        else $error("tap sequence not finished when result shown");

endmodule

FILE: sim/tb_multi_tap_sample_delay.sv
module tb_multi_tap_sample_delay;
    timeunit 1ns;
    timeprecision 1ps;

    import mtsd_pkg::*;

    localparam int     CLK_PERIOD = 12;
    localparam longint TIMEOUT_NS = 64'd48_000_000;
    localparam int     TAIL_CYCLES = 24;

    typedef logic [NUM_TAP_REGS-1:0][SAMPLE_W-1:0] t_tap_word;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata;   // sample_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;   // tap0_out .. tap7_out
    logic                   i_cfg_we;
    logic [TAP_IDX_W-1:0]   i_cfg_idx;
    logic [SETTING_W-1:0]   i_cfg_data;

    t_sample   hist_copy [HISTORY_SAMPLES];
    int        wr_slot;
    int        fill_cnt;
    t_setting  tap_cfg [NUM_TAP_REGS];
    t_tap_word tap_words_due [$];

    int err_count = 0;
    int rx_hold   = 0;
    int rx_stall  = 0;
    bit rx_idle_on = 1'b0;
    bit tx_idle_on = 1'b0;

    multi_tap_sample_delay u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_tap_word delay_line_predict(input t_sample smp);
        t_tap_word word;
        int        delay;
        word = '0;
        hist_copy[wr_slot] = smp;
        if (fill_cnt < int'(FILL_LIMIT)) begin
            fill_cnt++;
        end
        for (int k = 0; k < NUM_TAP_REGS; k++) begin
            if (k < TAP_COUNT && tap_cfg[k][ENABLE_BIT]) begin
                delay = int'(tap_cfg[k][DELAY_W-1:0]);
                if (delay < fill_cnt && delay < HISTORY_SAMPLES) begin
                    word[k] = hist_copy[(wr_slot + HISTORY_SAMPLES - delay) % HISTORY_SAMPLES];
                end
            end
        end
        wr_slot = (wr_slot + 1) % HISTORY_SAMPLES;
        return word;
    endfunction

    // Input acceptance is handled before the result check at the same edge.
    always @(posedge i_clk) begin : word_monitor
        t_tap_word due_word;
        t_sample   got;
        if (!i_rst_n) begin
            wr_slot  = 0;
            fill_cnt = 0;
            for (int k = 0; k < NUM_TAP_REGS; k++) begin
                tap_cfg[k] = '0;
            end
            tap_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                tap_cfg[i_cfg_idx] = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tap_words_due.push_back(delay_line_predict(t_sample'(s_axis_tdata)));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (tap_words_due.size() == 0) begin
                    err_count++;
                    $display("%0t: result word with no sample pending, expected none, got %h",
                             $time, m_axis_tdata);
                end else begin
                    due_word = tap_words_due.pop_front();
                    for (int k = 0; k < NUM_TAP_REGS; k++) begin
                        got = m_axis_tdata[k*SAMPLE_W +: SAMPLE_W];
                        if (got !== due_word[k]) begin
                            err_count++;
                            $display("%0t: tap %0d expected %0d, actual %0d", $time, k,
                                     $signed(due_word[k]), $signed(got));
                        end
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end else if (rx_stall > 0) begin
                m_axis_tready <= 1'b0;
                rx_stall--;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                rx_stall = pick_gap();
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_setting tap_word(input bit en, input int delay);
        return {en, DELAY_W'(delay)};
    endfunction

    function automatic t_sample rand_sample();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_setting rand_setting();
        int r;
        int delay;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            delay = $urandom_range(0, 40);
        end else if (r < 7) begin
            delay = $urandom_range(0, 1000);
        end else if (r == 7) begin
            delay = ($urandom_range(0, 1) == 0) ? 0 : 65535;
        end else begin
            delay = $urandom_range(0, 65535);
        end
        return tap_word($urandom_range(0, 4) != 0, delay);
    endfunction

    task automatic write_setting(input int idx, input t_setting value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= TAP_IDX_W'(idx);
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic send_sample(input t_sample smp);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tap_words_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_idle_outputs();
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        drain_results();
    endtask

    task automatic test_tap_extremes();
        t_setting cfg [NUM_TAP_REGS];
        t_sample  pattern [8];
        cfg[0] = tap_word(1'b1, 0);
        cfg[1] = tap_word(1'b1, 1);
        cfg[2] = tap_word(1'b1, 3);
        cfg[3] = tap_word(1'b1, 65535);
        cfg[4] = tap_word(1'b0, 0);
        cfg[5] = tap_word(1'b1, 32768);
        cfg[6] = tap_word(1'b1, 2);
        cfg[7] = tap_word(1'b0, 65535);
        pattern = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                    16'h5555, 16'hAAAA, 16'h0001, 16'hFFFE};
        for (int k = 0; k < NUM_TAP_REGS; k++) begin
            write_setting(k, cfg[k]);
        end
        foreach (pattern[i]) begin
            send_sample(pattern[i]);
        end
        repeat (4) send_sample(rand_sample());
        drain_results();
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int phase_len;
        int mode;
        sent = 0;
        while (sent < n_items) begin
            drain_results();
            for (int k = 0; k < NUM_TAP_REGS; k++) begin
                write_setting(k, rand_setting());
            end
            mode       = $urandom_range(0, 5);
            tx_idle_on = (mode == 1 || mode >= 3);
            rx_idle_on = (mode == 2 || mode >= 3);
            phase_len  = $urandom_range(20, 60);
            repeat (phase_len) send_sample(rand_sample());
            sent += phase_len;
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int k = 0; k < NUM_TAP_REGS; k++) begin
            write_setting(k, tap_word(1'b1, k * 3));
        end
        rx_hold = 300;
        repeat (30) send_sample(rand_sample());
        drain_results();
        rx_idle_on = 1'b1;
        repeat (10) send_sample(rand_sample());
        drain_results();
    endtask

    // Long delays reach back before the first sample and must stay zero,
    // while the short ones return real samples.
    task automatic test_long_delays();
        t_setting cfg [NUM_TAP_REGS];
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        cfg[0] = tap_word(1'b1, 0);
        cfg[1] = tap_word(1'b1, 65535);
        cfg[2] = tap_word(1'b1, 65534);
        cfg[3] = tap_word(1'b1, 32768);
        cfg[4] = tap_word(1'b1, 1);
        cfg[5] = tap_word(1'b1, 65533);
        cfg[6] = tap_word(1'b0, 65535);
        cfg[7] = rand_setting();
        for (int k = 0; k < NUM_TAP_REGS; k++) begin
            write_setting(k, cfg[k]);
        end
        repeat (48) send_sample(rand_sample());
        drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_outputs();
        test_tap_extremes();
        test_random_traffic(400);
        test_backpressure();
        test_long_delays();
        test_random_traffic(360);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: files.f
src/mtsd_pkg.sv
src/multi_tap_sample_delay.sv
sim/tb_multi_tap_sample_delay.sv
